FILE: sv/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the radial splat accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int X_BITS     = 9;
	localparam int Y_BITS     = 9;
	localparam int ADDR_BITS  = X_BITS + Y_BITS;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ACC_BITS   = 20;
	localparam int NUM_BITS   = 37;
	localparam int DEN_BITS   = 20;

	localparam logic [1:0] MODE_SPLAT = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [16:0] K_CORE = 17'd19661;
	localparam logic [16:0] K_042  = 17'd27525;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MODX, ST_MODY, ST_ACC, ST_RDW,
		ST_H2, ST_C2, ST_C2B, ST_SWX, ST_SWY,
		ST_PX, ST_PY, ST_PSUM, ST_PTEST, ST_SQRT, ST_SQD, ST_DIVW,
		ST_PU, ST_PU2, ST_PK1, ST_PK2, ST_PCH, ST_PWR, ST_FIN
	} state_t;

	typedef struct packed {
		logic                start;
		logic [NUM_BITS-1:0] num;
		logic [DEN_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [NUM_BITS-1:0] quot;
		logic [DEN_BITS-1:0] rem;
	} div_rsp_t;

endpackage

FILE: sv/radial_splat_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_splat_accumulator_unit
// Additive radial splats into a wrapping RGB accumulator framebuffer.
// ----------------------------------------------------------------------------
// write and read items wrap x and y with two divider runs
// a splat sets up, then visits each window pixel: outside the halo it steps on,
// inside the core and in the halo ring it adds (the ring with a 21-step square root
// and a division); one item is in work at a time, the divider sets the pace
// reset clears control state only; the framebuffer is undefined until written
module radial_splat_accumulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic signed [18:0] center_x,
	input  logic signed [18:0] center_y,
	input  logic [11:0] core_radius,
	input  logic [11:0] halo_radius,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic [8:0]  pixel_x,
	input  logic [8:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] out_red,
	output logic [19:0] out_green,
	output logic [19:0] out_blue
);
	import rsa_pkg::*;

	state_t state_q, state_d;

	logic [9:0] width_q, height_q;
	logic [9:0] w_eff, h_eff;

	logic [1:0]  mode_q;
	logic [7:0]  fx_q, fy_q;
	logic signed [11:0] vx_q, vy_q;
	logic [4:0]  rad_q;
	logic [11:0] halo_q, core_q;
	logic [15:0] rgb_q [3];
	logic [8:0]  pxin_q, pyin_q;
	logic [8:0]  px_q, py_q, pxs_q;
	logic signed [5:0] dx_q, dy_q;
	logic [25:0] d2_q;
	logic [23:0] halo2_q, core2_q;
	logic [41:0] sq_rem_q, sq_root_q, sq_bit_q;
	logic [4:0]  sq_cnt_q;
	logic [16:0] u_q;
	logic [14:0] k_q;
	logic [1:0]  ch_q;
	logic [19:0] acc_q [3];
	logic [59:0] pix_q;
	logic [59:0] res_q;
	logic [19:0] ored_q, ogreen_q, oblue_q;
	logic        out_valid_q;

	logic [59:0] mem_q [DEPTH];
	logic                 mem_we, mem_re;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [59:0]          mem_wdata;

	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] mul_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic accept;
	logic [4:0] rad_in;
	logic signed [14:0] ddx, ddy;
	logic [13:0] adx, ady;
	logic [10:0] avx, avy;
	logic [8:0]  wrap_x, wrap_y;
	logic [41:0] sq_try;
	logic        sq_ge;
	logic [19:0] num20, den20;
	logic [8:0]  px_inc, py_inc;
	logic        last_x, last_y;
	logic [14:0] rnd;
	logic [19:0] pix_ch;
	logic [20:0] ch_sum;

	rsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration port
	assign pready = 1'b1;
	assign prdata = {22'd0, paddr[2] ? height_q : width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd377;
			height_q <= 10'd510;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) height_q <= pwdata[9:0];
			else width_q <= pwdata[9:0];
		end
	end

	always_comb begin
		w_eff = (width_q == '0) ? 10'd1 : (width_q > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_q;
		h_eff = (height_q == '0) ? 10'd1 :
			(height_q > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : height_q;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// datapath helpers
	always_comb begin
		rad_in = 5'(({1'b0, halo_radius} + 13'd255) >> 8) + 5'd1;
		ddx = $signed({dx_q[5], dx_q, 8'h80}) - $signed({7'd0, fx_q});
		ddy = $signed({dy_q[5], dy_q, 8'h80}) - $signed({7'd0, fy_q});
		adx = ddx[14] ? 14'(-ddx) : ddx[13:0];
		ady = ddy[14] ? 14'(-ddy) : ddy[13:0];
		avx = vx_q[11] ? 11'(-vx_q) : vx_q[10:0];
		avy = vy_q[11] ? 11'(-vy_q) : vy_q[10:0];
		wrap_x = (vx_q[11] && div_rsp.rem != '0) ? 9'(w_eff - div_rsp.rem[9:0])
			: div_rsp.rem[8:0];
		wrap_y = (vy_q[11] && div_rsp.rem != '0) ? 9'(h_eff - div_rsp.rem[9:0])
			: div_rsp.rem[8:0];
		sq_try = sq_root_q + sq_bit_q;
		sq_ge  = sq_rem_q >= sq_try;
		num20  = {halo_q, 8'd0} - sq_root_q[19:0];
		den20  = {halo_q, 8'd0} - {core_q, 8'd0};
		px_inc = ({1'b0, px_q} + 10'd1 == w_eff) ? 9'd0 : px_q + 9'd1;
		py_inc = ({1'b0, py_q} + 10'd1 == h_eff) ? 9'd0 : py_q + 9'd1;
		last_x = dx_q == $signed({1'b0, rad_q});
		last_y = dy_q == $signed({1'b0, rad_q});
		rnd    = 15'((mul_q[31:0] + 32'd32768) >> 16);
		case (ch_q)
			2'd1:    pix_ch = pix_q[19:0];
			2'd2:    pix_ch = pix_q[39:20];
			default: pix_ch = pix_q[59:40];
		endcase
		ch_sum = {1'b0, pix_ch} + {6'd0, rnd};
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_H2:  begin mul_a = {20'd0, halo_q}; mul_b = {5'd0, halo_q}; end
			ST_C2:  begin mul_a = {20'd0, core_q}; mul_b = {5'd0, core_q}; end
			ST_PX:  begin mul_a = {18'd0, adx}; mul_b = {3'd0, adx}; end
			ST_PY:  begin mul_a = {18'd0, ady}; mul_b = {3'd0, ady}; end
			ST_PU:  begin mul_a = {15'd0, u_q}; mul_b = u_q; end
			ST_PU2: begin mul_a = {15'd0, mul_q[32:16]}; mul_b = K_042; end
			ST_PK1: begin mul_a = mul_q[31:0]; mul_b = K_CORE; end
			ST_PCH: begin
				if (ch_q != 2'd3) begin
					mul_a = {16'd0, rgb_q[ch_q]};
					mul_b = {2'd0, k_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				div_req.start = accept && (mode == MODE_WRITE || mode == MODE_READ);
				div_req.num   = NUM_BITS'(pixel_x);
				div_req.den   = DEN_BITS'(w_eff);
			end
			ST_MODX: begin
				div_req.start = div_rsp.done;
				div_req.num   = NUM_BITS'(pyin_q);
				div_req.den   = DEN_BITS'(h_eff);
			end
			ST_C2B: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_BITS'(avx);
				div_req.den   = DEN_BITS'(w_eff);
			end
			ST_SWX: begin
				div_req.start = div_rsp.done;
				div_req.num   = NUM_BITS'(avy);
				div_req.den   = DEN_BITS'(h_eff);
			end
			ST_SQD: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_BITS'({num20, 16'd0});
				div_req.den   = den20;
			end
			default: ;
		endcase
	end

	// framebuffer
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = {py_q, px_q};
		mem_wdata = {acc_q[2], acc_q[1], acc_q[0]};
		case (state_q)
			ST_ACC: begin
				mem_we    = (mode_q == MODE_WRITE);
				mem_re    = (mode_q == MODE_READ);
				mem_wdata = {4'd0, rgb_q[2], 4'd0, rgb_q[1], 4'd0, rgb_q[0]};
			end
			ST_PX:  mem_re = 1'b1;
			ST_PWR: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wdata;
		if (mem_re) pix_q <= mem_q[mem_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_SPLAT: state_d = ST_H2;
						MODE_WRITE, MODE_READ: state_d = ST_MODX;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_MODX: if (div_rsp.done) state_d = ST_MODY;
			ST_MODY: if (div_rsp.done) state_d = ST_ACC;
			ST_ACC:  state_d = (mode_q == MODE_READ) ? ST_RDW : ST_FIN;
			ST_RDW:  state_d = ST_FIN;
			ST_H2:   state_d = ST_C2;
			ST_C2:   state_d = ST_C2B;
			ST_C2B:  state_d = ST_SWX;
			ST_SWX:  if (div_rsp.done) state_d = ST_SWY;
			ST_SWY:  if (div_rsp.done) state_d = ST_PX;
			ST_PX:   state_d = ST_PY;
			ST_PY:   state_d = ST_PSUM;
			ST_PSUM: state_d = ST_PTEST;
			ST_PTEST: begin
				if ({2'd0, d2_q} >= {4'd0, halo2_q})
					state_d = (last_x && last_y) ? ST_FIN : ST_PX;
				else if ({2'd0, d2_q} <= {4'd0, core2_q}) state_d = ST_PCH;
				else state_d = ST_SQRT;
			end
			ST_SQRT: if (sq_cnt_q == '0) state_d = ST_SQD;
			ST_SQD:  state_d = ST_DIVW;
			ST_DIVW: if (div_rsp.done) state_d = ST_PU;
			ST_PU:   state_d = ST_PU2;
			ST_PU2:  state_d = ST_PK1;
			ST_PK1:  state_d = ST_PK2;
			ST_PK2:  state_d = ST_PCH;
			ST_PCH:  if (ch_q == 2'd3) state_d = ST_PWR;
			ST_PWR:  state_d = (last_x && last_y) ? ST_FIN : ST_PX;
			ST_FIN:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q   <= mode;
					fx_q     <= center_x[7:0];
					fy_q     <= center_y[7:0];
					rad_q    <= rad_in;
					vx_q     <= 12'($signed(center_x[18:8])) - $signed({7'd0, rad_in});
					vy_q     <= 12'($signed(center_y[18:8])) - $signed({7'd0, rad_in});
					halo_q   <= halo_radius;
					core_q   <= core_radius;
					rgb_q[0] <= red;
					rgb_q[1] <= green;
					rgb_q[2] <= blue;
					pxin_q   <= pixel_x;
					pyin_q   <= pixel_y;
					res_q    <= '0;
				end
			end
			ST_MODX: if (div_rsp.done) px_q <= div_rsp.rem[8:0];
			ST_MODY: if (div_rsp.done) py_q <= div_rsp.rem[8:0];
			ST_RDW:  res_q <= pix_q;
			ST_C2:   halo2_q <= mul_q[23:0];
			ST_C2B:  core2_q <= mul_q[23:0];
			ST_SWX: begin
				if (div_rsp.done) begin
					pxs_q <= wrap_x;
					px_q  <= wrap_x;
				end
			end
			ST_SWY: begin
				if (div_rsp.done) begin
					py_q <= wrap_y;
					dx_q <= -$signed({1'b0, rad_q});
					dy_q <= -$signed({1'b0, rad_q});
				end
			end
			ST_PY:   d2_q <= mul_q[25:0];
			ST_PSUM: d2_q <= d2_q + mul_q[25:0];
			ST_PTEST: begin
				ch_q      <= 2'd0;
				k_q       <= K_CORE[14:0];
				sq_rem_q  <= {d2_q, 16'd0};
				sq_root_q <= '0;
				sq_bit_q  <= 42'd1 << 40;
				sq_cnt_q  <= 5'd20;
				// pixel outside the halo: step on without a write
				if ({2'd0, d2_q} >= {4'd0, halo2_q}) begin
					if (last_x) begin
						dx_q <= -$signed({1'b0, rad_q});
						px_q <= pxs_q;
						dy_q <= dy_q + 6'sd1;
						py_q <= py_inc;
					end else begin
						dx_q <= dx_q + 6'sd1;
						px_q <= px_inc;
					end
				end
			end
			ST_SQRT: begin
				sq_cnt_q <= sq_cnt_q - 5'd1;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_ge) begin
					sq_rem_q  <= sq_rem_q - sq_try;
					sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
				end else begin
					sq_root_q <= sq_root_q >> 1;
				end
			end
			ST_DIVW: begin
				if (div_rsp.done)
					u_q <= (div_rsp.quot > 37'd65536) ? 17'd65536 : div_rsp.quot[16:0];
			end
			ST_PK2: k_q <= 15'((mul_q + 49'h0_8000_0000) >> 32);
			ST_PCH: begin
				ch_q <= ch_q + 2'd1;
				if (ch_q != 2'd0)
					acc_q[ch_q - 2'd1] <= ch_sum[20] ? {ACC_BITS{1'b1}} : ch_sum[19:0];
			end
			ST_PWR: begin
				if (last_x) begin
					dx_q <= -$signed({1'b0, rad_q});
					px_q <= pxs_q;
					dy_q <= dy_q + 6'sd1;
					py_q <= py_inc;
				end else begin
					dx_q <= dx_q + 6'sd1;
					px_q <= px_inc;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			ored_q   <= res_q[19:0];
			ogreen_q <= res_q[39:20];
			oblue_q  <= res_q[59:40];
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = ored_q;
	assign out_green = ogreen_q;
	assign out_blue  = oblue_q;

endmodule

FILE: sv/rsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module rsa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rsa_pkg::div_req_t req,
	output rsa_pkg::div_rsp_t rsp
);
	import rsa_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;
	logic                ge;

	always_comb begin
		trial = {rem_q, num_q[NUM_BITS-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
			num_q <= {num_q[NUM_BITS-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;

endmodule
